// ----- rtl/core/i2cmbw_pkg.sv -----
// ============================================================================
// i2cmbw_pkg
// Codes and types shared by the buffered write-only I2C master.
// ============================================================================
package i2cmbw_pkg;

    // request kinds carried in s_tuser
    typedef enum logic [1:0] {
        FN_BEGIN  = 2'd0,
        FN_APPEND = 2'd1,
        FN_END    = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    // completion status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_ADDR_NAK = 2'd2,
        ST_DATA_NAK = 2'd3
    } status_t;

    // bus sequencer phases, one-hot
    typedef enum logic [13:0] {
        PH_IDLE      = 14'b00000000000001,
        PH_START_A   = 14'b00000000000010,
        PH_START_B   = 14'b00000000000100,
        PH_BIT_SET   = 14'b00000000001000,
        PH_BIT_RISE  = 14'b00000000010000,
        PH_BIT_H1    = 14'b00000000100000,
        PH_BIT_H2    = 14'b00000001000000,
        PH_ACK_REL   = 14'b00000010000000,
        PH_ACK_RISE  = 14'b00000100000000,
        PH_ACK_H1    = 14'b00001000000000,
        PH_ACK_POLL  = 14'b00010000000000,
        PH_TAIL      = 14'b00100000000000,
        PH_STOP_HOLD = 14'b01000000000000,
        PH_STOP_END  = 14'b10000000000000
    } phase_t;

    // one result item, scl in the lowest bit
    typedef struct packed {
        status_t status;
        logic    done;
        logic    busy;
        logic    sda;
        logic    scl;
    } res_t;

    localparam logic [7:0] ACK_POLL_RESET = 8'd50;
    localparam logic [2:0] LAST_BIT       = 3'd7;
    localparam logic [7:0] TAIL_DELAYS    = 8'd1;
    localparam logic [7:0] STOP_DELAYS    = 8'd3;

    // register map
    localparam logic [2:0] ADDR_ACK_LIMIT = 3'd0;

endpackage

// ----- rtl/core/i2c_master_buffered_write_top.sv -----
// ============================================================================
// i2c_master_buffered_write_top
// Write-only I2C master with a byte buffer, stepped one delay unit per tick.
// ============================================================================
// Usage:
//   Requests arrive on the s_* stream: s_tuser selects begin, append, end or
//   tick; s_tdata carries the address, the data byte and the sampled SDA.
//   Every request yields exactly one result on the m_* stream with the pin
//   levels after the request, busy, a done pulse and the completion status.
//   Each tick request advances the bus sequencer by one delay unit.
//   Each result is registered in the output or skid register. One request is
//   taken in every cycle while s_tready is high, one state update per request.
//   The buffer is a memory written at one address while idle and read at the
//   byte pointer with a registered read, so no stall arises from it.
//   An output register plus a skid register hold results while the receiver
//   stalls: requests are still taken until both are full, then s_tready
//   drops until m_tready frees a slot.
//   After reset both pins are released, the buffer is empty and the poll limit is 50;
//   the buffer content itself is undefined until written. The user must write
//   ack_poll_limit over APB at byte address 0 only while idle; this is not enforced.
// ============================================================================
module i2c_master_buffered_write_top #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [6:0] target_address, [14:7] data_byte,
                                   // [15] sda_sample
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                   // [3] done_res, [5:4] status, [7:6] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [7:0] ack_limit_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == i2cmbw_pkg::ADDR_ACK_LIMIT);
    assign prdata = (paddr == i2cmbw_pkg::ADDR_ACK_LIMIT) ? {24'd0, ack_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_limit_reg <= i2cmbw_pkg::ACK_POLL_RESET;
        end
        else if (cfg_wr)
        begin
            ack_limit_reg <= pwdata[7:0];
        end
    end

    // ------------------------------------------------------------------
    // request fields
    // ------------------------------------------------------------------
    i2cmbw_pkg::func_t func;
    logic [6:0]        in_addr;
    logic [7:0]        in_data;
    logic              in_sda;
    logic              in_fire;

    assign func    = i2cmbw_pkg::func_t'(s_tuser);
    assign in_addr = s_tdata[6:0];
    assign in_data = s_tdata[14:7];
    assign in_sda  = s_tdata[15];
    assign in_fire = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    i2cmbw_pkg::phase_t  phase_reg, phase_next;
    i2cmbw_pkg::status_t pend_reg, pend_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic                ovf_reg, ovf_next;
    logic [6:0]          addr_reg, addr_next;
    logic [2:0]          bit_cnt_reg, bit_cnt_next;
    logic [7:0]          poll_reg, poll_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;

    logic [7:0]          buf_mem [BUFFER_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                buf_wr;
    logic [IDX_W-1:0]    wr_idx;
    logic [IDX_W-1:0]    rd_idx;

    logic                idle;
    logic [7:0]          cur_byte;
    logic                done_c;
    i2cmbw_pkg::status_t st_c;
    i2cmbw_pkg::res_t    res_c;

    assign idle     = (phase_reg == i2cmbw_pkg::PH_IDLE);
    assign cur_byte = (ptr_reg == '0) ? {addr_reg, 1'b0} : rd_data_reg;
    assign wr_idx   = IDX_W'(fill_reg);
    assign rd_idx   = IDX_W'(ptr_next - ONE_C);

    always_comb
    begin
        phase_next   = phase_reg;
        pend_next    = pend_reg;
        fill_next    = fill_reg;
        ptr_next     = ptr_reg;
        ovf_next     = ovf_reg;
        addr_next    = addr_reg;
        bit_cnt_next = bit_cnt_reg;
        poll_next    = poll_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        buf_wr       = 1'b0;
        done_c       = 1'b0;
        st_c         = i2cmbw_pkg::ST_OK;

        if (in_fire)
        begin
            if (func == i2cmbw_pkg::FN_TICK)
            begin
                if (!idle)
                begin
                    unique case (phase_reg)
                        i2cmbw_pkg::PH_START_A:
                        begin
                            sda_next   = 1'b0;
                            phase_next = i2cmbw_pkg::PH_START_B;
                        end
                        i2cmbw_pkg::PH_START_B:
                        begin
                            scl_next     = 1'b0;
                            bit_cnt_next = '0;
                            phase_next   = i2cmbw_pkg::PH_BIT_SET;
                        end
                        i2cmbw_pkg::PH_BIT_SET:
                        begin
                            sda_next   = cur_byte[3'(i2cmbw_pkg::LAST_BIT - bit_cnt_reg)];
                            phase_next = i2cmbw_pkg::PH_BIT_RISE;
                        end
                        i2cmbw_pkg::PH_BIT_RISE:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cmbw_pkg::PH_BIT_H1;
                        end
                        i2cmbw_pkg::PH_BIT_H1:
                        begin
                            phase_next = i2cmbw_pkg::PH_BIT_H2;
                        end
                        i2cmbw_pkg::PH_BIT_H2:
                        begin
                            scl_next = 1'b0;
                            if (bit_cnt_reg == i2cmbw_pkg::LAST_BIT)
                            begin
                                phase_next = i2cmbw_pkg::PH_ACK_REL;
                            end
                            else
                            begin
                                bit_cnt_next = bit_cnt_reg + 3'd1;
                                phase_next   = i2cmbw_pkg::PH_BIT_SET;
                            end
                        end
                        i2cmbw_pkg::PH_ACK_REL:
                        begin
                            sda_next   = 1'b1;
                            phase_next = i2cmbw_pkg::PH_ACK_RISE;
                        end
                        i2cmbw_pkg::PH_ACK_RISE:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cmbw_pkg::PH_ACK_H1;
                        end
                        i2cmbw_pkg::PH_ACK_H1:
                        begin
                            poll_next  = '0;
                            phase_next = i2cmbw_pkg::PH_ACK_POLL;
                        end
                        i2cmbw_pkg::PH_ACK_POLL:
                        begin
                            priority if (!in_sda)
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b0;
                                if (ptr_reg < fill_reg && ptr_reg < DEPTH_C)
                                begin
                                    ptr_next     = ptr_reg + ONE_C;
                                    bit_cnt_next = '0;
                                    phase_next   = i2cmbw_pkg::PH_BIT_SET;
                                end
                                else
                                begin
                                    poll_next  = '0;
                                    phase_next = i2cmbw_pkg::PH_TAIL;
                                end
                            end
                            else if (poll_reg >= ack_limit_reg)
                            begin
                                // missing ack: issue a stop and report an address or data NAK
                                pend_next  = (ptr_reg == '0) ? i2cmbw_pkg::ST_ADDR_NAK
                                                             : i2cmbw_pkg::ST_DATA_NAK;
                                sda_next   = 1'b0;
                                scl_next   = 1'b1;
                                poll_next  = '0;
                                phase_next = i2cmbw_pkg::PH_STOP_HOLD;
                            end
                            else
                            begin
                                poll_next = poll_reg + 8'd1;
                            end
                        end
                        i2cmbw_pkg::PH_TAIL:
                        begin
                            if (poll_reg >= i2cmbw_pkg::TAIL_DELAYS)
                            begin
                                fill_next  = '0;
                                ovf_next   = 1'b0;
                                pend_next  = i2cmbw_pkg::ST_OK;
                                sda_next   = 1'b0;
                                scl_next   = 1'b1;
                                poll_next  = '0;
                                phase_next = i2cmbw_pkg::PH_STOP_HOLD;
                            end
                            else
                            begin
                                poll_next = poll_reg + 8'd1;
                            end
                        end
                        i2cmbw_pkg::PH_STOP_HOLD:
                        begin
                            if (poll_reg >= i2cmbw_pkg::STOP_DELAYS)
                            begin
                                sda_next   = 1'b1;
                                phase_next = i2cmbw_pkg::PH_STOP_END;
                            end
                            else
                            begin
                                poll_next = poll_reg + 8'd1;
                            end
                        end
                        i2cmbw_pkg::PH_STOP_END:
                        begin
                            phase_next = i2cmbw_pkg::PH_IDLE;
                            done_c     = 1'b1;
                            st_c       = pend_reg;
                        end
                        default:
                        begin
                            phase_next = i2cmbw_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            else if (idle)
            begin
                priority if (func == i2cmbw_pkg::FN_BEGIN)
                begin
                    addr_next = in_addr;
                    fill_next = '0;
                    ovf_next  = 1'b0;
                end
                else if (func == i2cmbw_pkg::FN_APPEND)
                begin
                    if (fill_reg >= DEPTH_C)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        buf_wr    = 1'b1;
                        fill_next = fill_reg + ONE_C;
                    end
                end
                else if (ovf_reg)
                begin
                    done_c = 1'b1;
                    st_c   = i2cmbw_pkg::ST_OVERFLOW;
                end
                else
                begin
                    sda_next     = 1'b1;
                    scl_next     = 1'b1;
                    ptr_next     = '0;
                    bit_cnt_next = '0;
                    poll_next    = '0;
                    pend_next    = i2cmbw_pkg::ST_OK;
                    phase_next   = i2cmbw_pkg::PH_START_A;
                end
            end
        end

        res_c.scl    = scl_next;
        res_c.sda    = sda_next;
        res_c.busy   = (phase_next != i2cmbw_pkg::PH_IDLE);
        res_c.done   = done_c;
        res_c.status = st_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= i2cmbw_pkg::PH_IDLE;
            pend_reg    <= i2cmbw_pkg::ST_OK;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            ovf_reg     <= 1'b0;
            addr_reg    <= '0;
            bit_cnt_reg <= '0;
            poll_reg    <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end
        else
        begin
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
            ovf_reg     <= ovf_next;
            addr_reg    <= addr_next;
            bit_cnt_reg <= bit_cnt_next;
            poll_reg    <= poll_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

    // buffer: written only while idle, read ahead at the next byte pointer
    always_ff @(posedge clk)
    begin
        if (buf_wr)
        begin
            buf_mem[wr_idx] <= in_data;
        end
        rd_data_reg <= buf_mem[rd_idx];
    end

    // ------------------------------------------------------------------
    // output register with skid stage
    // ------------------------------------------------------------------
    i2cmbw_pkg::res_t out_reg;
    i2cmbw_pkg::res_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_tready)
        begin
            // advance the skid entry, or drop the taken result
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || m_tready)
            begin
                out_reg <= res_c;
            end
            else
            begin
                skid_reg <= res_c;
            end
        end
        else if (m_tready && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill count beyond buffer depth");

    a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done) |-> (out_reg.status == i2cmbw_pkg::ST_OK))
        else $error("status set without done");

    a_busy_holds_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (!idle && phase_reg != i2cmbw_pkg::PH_TAIL) |=> $stable(fill_reg))
        else $error("buffer fill changed during a transfer");
`endif

endmodule
